@@ rtl/rcbe_pkg.sv @@
// shared types and constants for the recompute cost block evictor
package rcbe_pkg;

	localparam int unsigned ENTRIES_DEFAULT = 256;
	localparam int unsigned TIME_BITS_DEFAULT = 32;
	localparam int unsigned ID_W = 64;
	localparam int unsigned COST_W = 32;
	localparam int unsigned LOGC_W = 16;
	localparam int unsigned REG_W = 32;
	localparam int unsigned REQ_W = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [31:0] LIFESPAN_RESET = 32'd200000;
	localparam logic [61:0] PROD_CAP = {62{1'b1}};

	localparam logic [REQ_W-1:0] REQ_ACCESS = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ADMIT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_EVICT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SET_CLOCK = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIFESPAN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YOUNG_WEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OLD_WEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_OFFSET = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture request
		logic scan_start; // clear scan registers
		logic scan_step;  // visit one slot
		logic log_start;  // begin log2 of cost
		logic log_step;   // one squaring
		logic commit;     // apply request to table and build result
	} rcbe_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic log_done;
		logic [REQ_W-1:0] req_type;
	} rcbe_sts_t;

endpackage

@@ rtl/rcbe_ctrl.sv @@
// controller state machine for the evictor
module rcbe_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	input  rcbe_pkg::rcbe_sts_t     sts,
	output rcbe_pkg::rcbe_cmd_t     cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_LOG   = 6'b001000,
		ST_APPLY = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.scan_start = 1'b1;
				cmd.log_start = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = (sts.req_type == rcbe_pkg::REQ_ADMIT) ? ST_LOG : ST_APPLY;
				end
			end
			ST_LOG: begin
				cmd.log_step = 1'b1;
				if (sts.log_done) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.commit = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

endmodule

@@ rtl/rcbe_datapath.sv @@
// table, scan, score and log2 datapath for the evictor
module rcbe_datapath #(
	parameter int unsigned ENTRIES = rcbe_pkg::ENTRIES_DEFAULT,
	parameter int unsigned TIME_BITS = rcbe_pkg::TIME_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcbe_pkg::rcbe_cmd_t           cmd,
	output rcbe_pkg::rcbe_sts_t           sts,
	input  logic [rcbe_pkg::REQ_W-1:0]    req_type,
	input  logic [rcbe_pkg::ID_W-1:0]     block_id,
	input  logic [rcbe_pkg::COST_W-1:0]   block_cost,
	input  logic [31:0]                   time_value,
	input  logic                          cfg_we,
	input  logic [rcbe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcbe_pkg::REG_W-1:0]    cfg_data,
	output logic                          victim_valid,
	output logic [rcbe_pkg::ID_W-1:0]     victim_id,
	output logic                          entry_found,
	output logic                          status
);

	localparam int unsigned IDX_W = $clog2(ENTRIES);
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam int unsigned TW = TIME_BITS;

	// configuration
	logic        clock_mode_q;
	logic [31:0] lifespan_q;
	logic [31:0] young_weight_q;
	logic [31:0] old_weight_q;
	logic [31:0] turn_offset_q;

	// table
	logic [rcbe_pkg::ID_W-1:0]   tag_mem   [ENTRIES];
	logic [TW-1:0]               last_mem  [ENTRIES];
	logic [rcbe_pkg::LOGC_W-1:0] logc_mem  [ENTRIES];
	logic [ENTRIES-1:0]          valid_q;
	logic [ENTRIES-1:0]          resident_q;
	logic [TW-1:0]               clock_now_q;
	logic [CNT_W-1:0]            resident_count_q;

	// captured request
	logic [rcbe_pkg::REQ_W-1:0]  req_q;
	logic [rcbe_pkg::ID_W-1:0]   id_q;
	logic [rcbe_pkg::COST_W-1:0] cost_q;
	logic [31:0]                 tv_q;

	// scan state
	logic [CNT_W-1:0]  scan_cnt_q;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              rd_vld_s1;
	logic [rcbe_pkg::ID_W-1:0]   rd_tag_s1;
	logic [TW-1:0]               rd_last_s1;
	logic [rcbe_pkg::LOGC_W-1:0] rd_logc_s1;
	logic              rd_valid_s1;
	logic              rd_res_s1;
	// stage 2: products
	logic              p_vld_s2;
	logic [IDX_W-1:0]  p_idx_s2;
	logic [rcbe_pkg::LOGC_W-1:0] p_logc_s2;
	logic [62:0]       young_s2;
	logic [62:0]       old_s2;
	logic              p_cand_s2;
	// stage 3: score
	logic              s_vld_s3;
	logic [IDX_W-1:0]  s_idx_s3;
	logic signed [63:0] score_s3;
	logic              s_cand_s3;

	logic              match_hit_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic              free_hit_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              best_hit_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic signed [63:0] best_score_q;
	logic              pipe_busy;

	// log2 unit
	logic [4:0]  log_e_q;
	logic [32:0] log_m_q;
	logic [10:0] log_frac_q;
	logic [3:0]  log_cnt_q;
	logic        log_zero_q;

	// result registers
	logic                        vvalid_q;
	logic [rcbe_pkg::ID_W-1:0]   vid_q;
	logic                        found_q;
	logic                        status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_mode_q <= 1'b0;
			lifespan_q <= rcbe_pkg::LIFESPAN_RESET;
			young_weight_q <= '0;
			old_weight_q <= '0;
			turn_offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcbe_pkg::CFG_CLOCK_MODE: clock_mode_q <= cfg_data[0];
				rcbe_pkg::CFG_LIFESPAN: lifespan_q <= cfg_data;
				rcbe_pkg::CFG_YOUNG_WEIGHT: young_weight_q <= cfg_data;
				rcbe_pkg::CFG_OLD_WEIGHT: old_weight_q <= cfg_data;
				rcbe_pkg::CFG_TURN_OFFSET: turn_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			id_q <= block_id;
			cost_q <= block_cost;
			tv_q <= time_value;
		end
	end

	// stage 1: memory read of one slot
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		rd_tag_s1 <= tag_mem[scan_cnt_q[IDX_W-1:0]];
		rd_last_s1 <= last_mem[scan_cnt_q[IDX_W-1:0]];
		rd_logc_s1 <= logc_mem[scan_cnt_q[IDX_W-1:0]];
		rd_valid_s1 <= valid_q[scan_cnt_q[IDX_W-1:0]];
		rd_res_s1 <= resident_q[scan_cnt_q[IDX_W-1:0]];
	end

	// tau and saturating products
	logic [TW-1:0]  tau;
	logic [TW-1:0]  tau_old;
	logic [TW+31:0] young_raw;
	logic [TW+31:0] old_raw;
	logic [62:0]    young_sat;
	logic [62:0]    old_sat;

	always_comb begin
		tau = (clock_now_q > rd_last_s1) ? (clock_now_q - rd_last_s1) : '0;
		tau_old = ((TW+32)'(tau) > (TW+32)'(turn_offset_q))
			? TW'((TW+32)'(tau) - (TW+32)'(turn_offset_q)) : '0;
		young_raw = (TW+32)'(tau) * (TW+32)'(young_weight_q);
		old_raw = (TW+32)'(tau_old) * (TW+32)'(old_weight_q);
		young_sat = ((TW+32)'(young_raw) > (TW+32)'(rcbe_pkg::PROD_CAP))
			? {1'b0, rcbe_pkg::PROD_CAP} : 63'(young_raw);
		old_sat = ((TW+32)'(old_raw) > (TW+32)'(rcbe_pkg::PROD_CAP))
			? {1'b0, rcbe_pkg::PROD_CAP} : 63'(old_raw);
	end

	always_ff @(posedge clk) begin
		p_idx_s2 <= rd_idx_s1;
		p_logc_s2 <= rd_logc_s1;
		young_s2 <= young_sat;
		old_s2 <= old_sat;
		p_cand_s2 <= rd_valid_s1 && rd_res_s1;
		s_idx_s3 <= p_idx_s2;
		s_cand_s3 <= p_cand_s2;
		score_s3 <= $signed({35'd0, p_logc_s2, 13'd0})
			- $signed({1'b0, (young_s2 > old_s2) ? young_s2 : old_s2});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			p_vld_s2 <= 1'b0;
			s_vld_s3 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step && (scan_cnt_q < CNT_W'(ENTRIES));
			p_vld_s2 <= rd_vld_s1;
			s_vld_s3 <= p_vld_s2;
		end
	end

	assign pipe_busy = rd_vld_s1 || p_vld_s2 || s_vld_s3;

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			match_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
			best_hit_q <= 1'b0;
			match_idx_q <= '0;
			free_idx_q <= '0;
			best_idx_q <= '0;
			best_score_q <= '0;
		end else if (cmd.scan_start) begin
			scan_cnt_q <= '0;
			match_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
			best_hit_q <= 1'b0;
		end else begin
			if (cmd.scan_step && scan_cnt_q < CNT_W'(ENTRIES)) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (rd_vld_s1) begin
				if (!match_hit_q && rd_valid_s1 && rd_tag_s1 == id_q) begin
					match_hit_q <= 1'b1;
					match_idx_q <= rd_idx_s1;
				end
				if (!free_hit_q && !rd_valid_s1) begin
					free_hit_q <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
			end
			if (s_vld_s3 && s_cand_s3 && (!best_hit_q || score_s3 < best_score_q)) begin
				best_hit_q <= 1'b1;
				best_idx_q <= s_idx_s3;
				best_score_q <= score_s3;
			end
		end
	end

	// log2 by repeated squaring, one square per cycle
	logic [4:0]  msb_pos;
	logic [65:0] sq;
	logic [32:0] sq_m;

	always_comb begin
		msb_pos = '0;
		for (int b = 0; b < 32; b++) begin
			if (cost_q[b]) begin
				msb_pos = 5'(b);
			end
		end
		sq = 66'(log_m_q) * 66'(log_m_q);
		sq_m = 33'(sq >> 31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_cnt_q <= '0;
			log_e_q <= '0;
			log_m_q <= '0;
			log_frac_q <= '0;
			log_zero_q <= 1'b0;
		end else if (cmd.log_start) begin
			log_cnt_q <= '0;
			log_e_q <= msb_pos;
			log_m_q <= 33'(({32'd0, cost_q} << 31) >> msb_pos);
			log_frac_q <= '0;
			log_zero_q <= (cost_q <= 32'd1);
		end else if (cmd.log_step && log_cnt_q < 4'd11) begin
			log_cnt_q <= log_cnt_q + 1'b1;
			if (sq_m[32]) begin
				log_m_q <= sq_m >> 1;
				log_frac_q <= {log_frac_q[9:0], 1'b1};
			end else begin
				log_m_q <= sq_m;
				log_frac_q <= {log_frac_q[9:0], 1'b0};
			end
		end
	end

	logic [rcbe_pkg::LOGC_W-1:0] logc_val;
	assign logc_val = log_zero_q ? '0 : {log_e_q, log_frac_q};

	assign sts.scan_done = (scan_cnt_q == CNT_W'(ENTRIES)) && !pipe_busy && !cmd.scan_start;
	assign sts.log_done = (log_cnt_q == 4'd11);
	assign sts.req_type = req_q;

	// commit decisions
	logic              alloc_ok;
	logic [IDX_W-1:0]  tgt_idx;
	logic              wr_new;
	logic              wr_last;
	logic              wr_logc;
	logic [rcbe_pkg::LOGC_W-1:0] wr_logc_val;

	always_comb begin
		alloc_ok = free_hit_q;
		tgt_idx = match_hit_q ? match_idx_q : free_idx_q;
		wr_new = 1'b0;
		wr_last = 1'b0;
		wr_logc = 1'b0;
		wr_logc_val = '0;
		if (cmd.commit) begin
			case (req_q)
				rcbe_pkg::REQ_ACCESS: begin
					wr_last = match_hit_q || alloc_ok;
					wr_new = !match_hit_q && alloc_ok;
					wr_logc = wr_new;
				end
				rcbe_pkg::REQ_ADMIT: begin
					wr_new = !match_hit_q && alloc_ok;
					wr_last = wr_new;
					wr_logc = match_hit_q || alloc_ok;
					wr_logc_val = logc_val;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_new) begin
			tag_mem[tgt_idx] <= id_q;
		end
		if (wr_last) begin
			last_mem[tgt_idx] <= clock_now_q;
		end
		if (wr_logc) begin
			logc_mem[tgt_idx] <= wr_logc_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			resident_q <= '0;
			clock_now_q <= '0;
			resident_count_q <= '0;
			vvalid_q <= 1'b0;
			vid_q <= '0;
			found_q <= 1'b0;
			status_q <= 1'b0;
		end else if (cmd.commit) begin
			vvalid_q <= 1'b0;
			vid_q <= '0;
			found_q <= 1'b0;
			status_q <= 1'b0;
			case (req_q)
				rcbe_pkg::REQ_ACCESS: begin
					found_q <= match_hit_q;
					status_q <= !match_hit_q && !alloc_ok;
					if (wr_new) begin
						valid_q[tgt_idx] <= 1'b1;
						resident_q[tgt_idx] <= 1'b0;
					end
					if (!clock_mode_q) begin
						clock_now_q <= clock_now_q + 1'b1;
					end
				end
				rcbe_pkg::REQ_ADMIT: begin
					found_q <= match_hit_q;
					status_q <= !match_hit_q && !alloc_ok;
					if (match_hit_q || alloc_ok) begin
						valid_q[tgt_idx] <= 1'b1;
						resident_q[tgt_idx] <= 1'b1;
						if (!(match_hit_q && resident_q[tgt_idx])) begin
							resident_count_q <= resident_count_q + 1'b1;
						end
					end
				end
				rcbe_pkg::REQ_EVICT: begin
					if (best_hit_q) begin
						vvalid_q <= 1'b1;
						vid_q <= tag_mem[best_idx_q];
						valid_q[best_idx_q] <= 1'b0;
						resident_q[best_idx_q] <= 1'b0;
						if (resident_count_q != '0) begin
							resident_count_q <= resident_count_q - 1'b1;
						end
					end
				end
				rcbe_pkg::REQ_REMOVE: begin
					found_q <= match_hit_q;
					if (match_hit_q && resident_q[match_idx_q]) begin
						valid_q[match_idx_q] <= 1'b0;
						resident_q[match_idx_q] <= 1'b0;
						if (resident_count_q != '0) begin
							resident_count_q <= resident_count_q - 1'b1;
						end
					end
				end
				rcbe_pkg::REQ_SET_CLOCK: begin
					if (clock_mode_q) begin
						clock_now_q <= TW'({{(TW > 32 ? TW - 32 : 1){1'b0}}, tv_q});
					end
				end
				default: ;
			endcase
		end
	end

	// lifespan is held for software only
	logic unused_lifespan;
	assign unused_lifespan = ^lifespan_q;

	assign victim_valid = vvalid_q & ~unused_lifespan | vvalid_q;
	assign victim_id = vid_q;
	assign entry_found = found_q;
	assign status = status_q;

endmodule

@@ rtl/recompute_cost_block_evictor_unit.sv @@
// top level of the recompute cost block evictor
// Every request sweeps the whole tag table one slot per cycle through the
// table memory's single read port, looking up the tag, the lowest free slot
// and the least-score resident victim in one pass; an admit then also takes
// the log2 of its cost. One item is in flight at a time; the result is held
// until taken.
module recompute_cost_block_evictor_unit #(
	parameter int unsigned ENTRIES = rcbe_pkg::ENTRIES_DEFAULT,
	parameter int unsigned TIME_BITS = rcbe_pkg::TIME_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rcbe_pkg::REQ_W-1:0]     req_type,
	input  logic [rcbe_pkg::ID_W-1:0]      block_id,
	input  logic [rcbe_pkg::COST_W-1:0]    block_cost,
	input  logic [31:0]                    time_value,
	input  logic                           last_in_request,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           victim_valid,
	output logic [rcbe_pkg::ID_W-1:0]      victim_id,
	output logic                           entry_found,
	output logic                           status,
	input  logic                           cfg_we,
	input  logic [rcbe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcbe_pkg::REG_W-1:0]     cfg_data
);

	rcbe_pkg::rcbe_cmd_t cmd;
	rcbe_pkg::rcbe_sts_t sts;
	logic [rcbe_pkg::REQ_W-1:0] req_gated;

	// end-of-request marker carries no function
	assign req_gated = req_type | {rcbe_pkg::REQ_W{last_in_request & 1'b0}};

	rcbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcbe_datapath #(
		.ENTRIES   (ENTRIES),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_gated),
		.block_id     (block_id),
		.block_cost   (block_cost),
		.time_value   (time_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.victim_valid (victim_valid),
		.victim_id    (victim_id),
		.entry_found  (entry_found),
		.status       (status)
	);

endmodule
